// ----- rtl/core/rtbs_pkg.sv -----
// Shared types and constants of the record-to-block segmenter.
// Used by rtbs_emit, record_to_block_segmenter_core and the testbench; depends on nothing.
package rtbs_pkg;

  localparam int unsigned UsedW    = 23;
  localparam int unsigned HbW      = 7;
  localparam int unsigned HvW      = 2;
  localparam int unsigned IdxW     = 31;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HdrCntW  = 5;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned HdrWords = 5;

  localparam logic [UsedW-1:0] MaxBlockBytes = 23'd4194304;

  localparam logic [UsedW-1:0] CapReset = 23'd64512;
  localparam logic [HbW-1:0]   HbReset  = 7'd24;
  localparam logic [HvW-1:0]   HvReset  = 2'd2;

  localparam logic [HvW-1:0]     HdrVersionLong = 2'd1;
  localparam logic [HdrCntW-1:0] HdrLenLong     = 5'd20;
  localparam logic [HdrCntW-1:0] HdrLenShort    = 5'd12;
  localparam logic [HdrCntW-1:0] HdrStartLong   = 5'd0;
  localparam logic [HdrCntW-1:0] HdrStartShort  = 5'd8;
  localparam logic [HdrCntW-1:0] HdrLastByte    = 5'd19;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_PAYLOAD = 2'd1,
    REQ_FLUSH   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    REG_CAPACITY  = 2'd0,
    REG_HDR_BYTES = 2'd1,
    REG_VERSION   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_END_PRE,
    PH_HDR,
    PH_BYTE,
    PH_END_POST,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [31:0]       session_id;
    logic [31:0]       session_time;
    logic signed [31:0] file_index;
    logic [30:0]       stream_id;
    logic [31:0]       data_length;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        record_done;
    logic        last_of_run;
    logic [22:0] block_used;
    logic [30:0] first_index;
    logic [30:0] last_index;
    logic [31:0] block_session_id;
    logic [31:0] block_session_time;
  } out_item_t;

  // Snapshot reported by one block-end beat.
  typedef struct packed {
    logic [UsedW-1:0] used;
    logic [IdxW-1:0]  first;
    logic [IdxW-1:0]  last;
    logic [WordW-1:0] sid;
    logic [WordW-1:0] stime;
  } end_info_t;

  // Everything one input item emits, worked out when it is accepted.
  typedef struct packed {
    logic                          end_pre;
    end_info_t                     end_pre_info;
    logic                          hdr_en;
    logic                          hdr_long;
    logic                          hdr_done;
    logic [HdrWords-1:0][WordW-1:0] hdr_word;
    logic                          byte_en;
    logic [7:0]                    byte_val;
    logic                          byte_done;
    logic                          end_post;
    end_info_t                     end_post_info;
  } plan_t;

endpackage

// ----- rtl/core/rtbs_emit.sv -----
// Result sequencer: holds one item plan and plays it out one beat a cycle while the output is not stalled.
// Depends on rtbs_pkg (plan_t, out_item_t, phase_e).
module rtbs_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               plan_valid_i,
  input  rtbs_pkg::plan_t    plan_i,
  output logic               plan_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtbs_pkg::out_item_t out_data_o
);
  import rtbs_pkg::*;

  plan_t               plan_q;
  phase_e              phase_q, phase_d, phase_after, phase_first;
  logic [HdrCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q;
  out_item_t           out_q, res;
  logic                fire, load, last_res;
  logic [WordW-1:0]    hdr_w;

  assign fire     = (phase_q != PH_DONE) && (!out_valid_q || !out_stall_i);
  assign last_res = (phase_after == PH_DONE);
  assign plan_ready_o = (phase_q == PH_DONE) || (fire && last_res);
  assign load     = plan_valid_i && plan_ready_o;

  // Next state.
  always_comb begin
    phase_after = PH_DONE;
    unique case (phase_q)
      PH_END_PRE: begin
        if (plan_q.hdr_en)        phase_after = PH_HDR;
        else if (plan_q.byte_en)  phase_after = PH_BYTE;
        else if (plan_q.end_post) phase_after = PH_END_POST;
      end
      PH_HDR: begin
        if (cnt_q != HdrLastByte) phase_after = PH_HDR;
        else if (plan_q.byte_en)  phase_after = PH_BYTE;
        else if (plan_q.end_post) phase_after = PH_END_POST;
      end
      PH_BYTE: begin
        if (plan_q.end_post) phase_after = PH_END_POST;
      end
      PH_END_POST, PH_DONE: phase_after = PH_DONE;
      default: phase_after = PH_DONE;
    endcase

    if (plan_i.end_pre)       phase_first = PH_END_PRE;
    else if (plan_i.hdr_en)   phase_first = PH_HDR;
    else if (plan_i.byte_en)  phase_first = PH_BYTE;
    else if (plan_i.end_post) phase_first = PH_END_POST;
    else                      phase_first = PH_DONE;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (fire) begin
      phase_d = phase_after;
      if (phase_q == PH_HDR) cnt_d = cnt_q + HdrCntW'(1);
    end
    if (load) begin
      phase_d = phase_first;
      cnt_d   = plan_i.hdr_long ? HdrStartLong : HdrStartShort;
    end
  end

  // Outputs: the beat for the current phase.
  always_comb begin
    hdr_w = plan_q.hdr_word[cnt_q[4:2]];
    res   = '0;
    res.last_of_run = last_res;
    unique case (phase_q)
      PH_END_PRE: begin
        res.kind               = KindEnd;
        res.block_used         = plan_q.end_pre_info.used;
        res.first_index        = plan_q.end_pre_info.first;
        res.last_index         = plan_q.end_pre_info.last;
        res.block_session_id   = plan_q.end_pre_info.sid;
        res.block_session_time = plan_q.end_pre_info.stime;
      end
      PH_HDR: begin
        res.kind = KindByte;
        unique case (cnt_q[1:0])
          2'd0: res.out_byte = hdr_w[31:24];
          2'd1: res.out_byte = hdr_w[23:16];
          2'd2: res.out_byte = hdr_w[15:8];
          2'd3: res.out_byte = hdr_w[7:0];
          default: res.out_byte = hdr_w[7:0];
        endcase
        res.record_done = plan_q.hdr_done && (cnt_q == HdrLastByte);
      end
      PH_BYTE: begin
        res.kind        = KindByte;
        res.out_byte    = plan_q.byte_val;
        res.record_done = plan_q.byte_done;
      end
      PH_END_POST: begin
        res.kind               = KindEnd;
        res.block_used         = plan_q.end_post_info.used;
        res.first_index        = plan_q.end_post_info.first;
        res.last_index         = plan_q.end_post_info.last;
        res.block_session_id   = plan_q.end_post_info.sid;
        res.block_session_time = plan_q.end_post_info.stime;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (fire)             out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) plan_q <= plan_i;
    if (fire) out_q  <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/record_to_block_segmenter_core.sv -----
// Record-to-block segmenter, top level: config registers, block state and
// per-item planning. Depends on rtbs_pkg and rtbs_emit.
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_stall_o  | one request (in_item_t)
//  out     | source    | out_valid_o / out_stall_i| one block byte or block end
//  cfg     | sink      | psel/penable/pready     | one 32-bit register access
//
// Each accepted item yields 0 to 22 out beats, one beat per cycle while
// the output is not stalled, so a plain payload byte sustains one item
// per cycle and a header burst holds the input until its beats are out.
// The next item is taken in the cycle the last beat of the current one
// moves into the output register. Reset (rst_ni low, asynchronous)
// empties the sequencer and output register, clears the block state and
// loads the register defaults. A stall on the output holds the output
// register and the sequencer and backs up into in_stall_o.
module record_to_block_segmenter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rtbs_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rtbs_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rtbs_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rtbs_pkg::CfgDataW-1:0]   pwdata,
  output logic [rtbs_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import rtbs_pkg::*;

  // Configuration registers.
  logic [UsedW-1:0] cap_q;
  logic [HbW-1:0]   hb_q;
  logic [HvW-1:0]   hv_q;

  // Block and record state.
  logic [UsedW-1:0] used_q;
  logic [WordW-1:0] bytes_left_q;
  logic             open_q, need_q;
  logic [WordW-1:0] cur_sid_q, cur_stime_q, cur_fidx_q;
  logic [IdxW-1:0]  cur_stream_q;
  logic [IdxW-1:0]  first_q, last_q;
  logic [WordW-1:0] bsid_q, bstime_q;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  logic             plan_ready, accept, active;
  logic             is_begin, is_pay, is_flush;
  plan_t            plan;

  logic [HdrCntW-1:0] hdr_len;
  logic [UsedW-1:0]   cap_lim, cap_min, cap_eff;
  logic [UsedW:0]     hdr_sum;
  logic               pre_end, hdr_en, post_end, idx_pos, open_after;
  logic [UsedW-1:0]   used1, used2, used3, used4;
  logic [IdxW-1:0]    first1, last1, first2, last2, first4, last4;
  logic [WordW-1:0]   h_sid, h_stime, h_fidx, h_stream_w, h_len_w;
  logic [WordW-1:0]   bsid2, bstime2, left3;

  // Config port: zero-wait, written in the access phase.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    priority if (cfg_idx == REG_CAPACITY)  prdata = CfgDataW'(cap_q);
    else if (cfg_idx == REG_HDR_BYTES)      prdata = CfgDataW'(hb_q);
    else if (cfg_idx == REG_VERSION)        prdata = CfgDataW'(hv_q);
    else                                    prdata = '0;
  end

  // Effective capacity: clamp to the maximum, then leave room for the block
  // header, one record header and two payload bytes.
  assign hdr_len = (hv_q == HdrVersionLong) ? HdrLenLong : HdrLenShort;
  assign cap_lim = (cap_q > MaxBlockBytes) ? MaxBlockBytes : cap_q;
  assign cap_min = UsedW'(hb_q) + UsedW'(hdr_len) + UsedW'(2);
  assign cap_eff = (cap_lim < cap_min) ? cap_min : cap_lim;

  assign is_begin = (in_data_i.req_type == REQ_BEGIN);
  assign is_pay   = (in_data_i.req_type == REQ_PAYLOAD) && open_q;
  assign is_flush = (in_data_i.req_type == REQ_FLUSH);
  assign active   = is_begin || is_pay || is_flush;

  always_comb begin
    // End before the header or byte when it no longer fits, or on a flush.
    hdr_sum = {1'b0, used_q} + (UsedW+1)'(hdr_len);
    pre_end = is_flush
           || (is_begin && (hdr_sum > {1'b0, cap_eff}))
           || (is_pay && need_q && (hdr_sum >= {1'b0, cap_eff}))
           || (is_pay && !need_q && (used_q >= cap_eff));
    used1  = pre_end ? UsedW'(hb_q) : used_q;
    first1 = pre_end ? '0 : first_q;
    last1  = pre_end ? '0 : last_q;

    // Record header, fresh or continuation; a payload byte that ends the
    // block first resumes behind a continuation header.
    hdr_en     = is_begin || (is_pay && (need_q || pre_end));
    h_sid      = is_begin ? in_data_i.session_id   : cur_sid_q;
    h_stime    = is_begin ? in_data_i.session_time : cur_stime_q;
    h_fidx     = is_begin ? WordW'(in_data_i.file_index) : cur_fidx_q;
    h_stream_w = is_begin ? {1'b0, in_data_i.stream_id}
                          : (WordW'(0) - {1'b0, cur_stream_q});
    h_len_w    = is_begin ? in_data_i.data_length : bytes_left_q;
    idx_pos    = (h_fidx != '0) && !h_fidx[WordW-1];

    used2   = hdr_en ? (used1 + UsedW'(hdr_len)) : used1;
    first2  = (hdr_en && idx_pos && (first1 == '0)) ? h_fidx[IdxW-1:0] : first1;
    last2   = (hdr_en && idx_pos) ? h_fidx[IdxW-1:0] : last1;
    bsid2   = (hdr_en && (hv_q != HdrVersionLong)) ? h_sid   : bsid_q;
    bstime2 = (hdr_en && (hv_q != HdrVersionLong)) ? h_stime : bstime_q;

    // Payload byte.
    left3 = bytes_left_q - WordW'(1);
    used3 = is_pay ? (used2 + UsedW'(1)) : used2;

    // End after when the record goes on and the block is full.
    open_after = is_begin ? (in_data_i.data_length != '0) : (left3 != '0);
    post_end   = (is_begin || is_pay) && open_after && (used3 >= cap_eff);
    used4  = post_end ? UsedW'(hb_q) : used3;
    first4 = post_end ? '0 : first2;
    last4  = post_end ? '0 : last2;
  end

  always_comb begin
    plan                     = '0;
    plan.end_pre             = pre_end;
    plan.end_pre_info.used   = used_q;
    plan.end_pre_info.first  = first_q;
    plan.end_pre_info.last   = last_q;
    plan.end_pre_info.sid    = bsid_q;
    plan.end_pre_info.stime  = bstime_q;
    plan.hdr_en              = hdr_en;
    plan.hdr_long            = (hv_q == HdrVersionLong);
    plan.hdr_done            = is_begin && (in_data_i.data_length == '0);
    plan.hdr_word[0]         = h_sid;
    plan.hdr_word[1]         = h_stime;
    plan.hdr_word[2]         = h_fidx;
    plan.hdr_word[3]         = h_stream_w;
    plan.hdr_word[4]         = h_len_w;
    plan.byte_en             = is_pay;
    plan.byte_val            = in_data_i.data_byte;
    plan.byte_done           = (left3 == '0);
    plan.end_post            = post_end;
    plan.end_post_info.used  = used3;
    plan.end_post_info.first = first2;
    plan.end_post_info.last  = last2;
    plan.end_post_info.sid   = bsid2;
    plan.end_post_info.stime = bstime2;
  end

  // Hold the input while the plan register still has beats to play.
  assign in_stall_o = !plan_ready;
  assign accept     = in_valid_i && plan_ready;

  rtbs_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_valid_i(accept && active),
    .plan_i      (plan),
    .plan_ready_o(plan_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CapReset;
      hb_q         <= HbReset;
      hv_q         <= HvReset;
      used_q       <= UsedW'(HbReset);
      bytes_left_q <= '0;
      open_q       <= 1'b0;
      need_q       <= 1'b0;
      cur_sid_q    <= '0;
      cur_stime_q  <= '0;
      cur_fidx_q   <= '0;
      cur_stream_q <= '0;
      first_q      <= '0;
      last_q       <= '0;
      bsid_q       <= '0;
      bstime_q     <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_idx == REG_CAPACITY) cap_q <= pwdata[UsedW-1:0];
        if (cfg_idx == REG_VERSION)  hv_q  <= pwdata[HvW-1:0];
        if (cfg_idx == REG_HDR_BYTES) begin
          hb_q <= pwdata[HbW-1:0];
          // An untouched block takes the new reservation at once.
          if (used_q == UsedW'(hb_q)) used_q <= UsedW'(pwdata[HbW-1:0]);
        end
      end else if (accept && active) begin
        used_q   <= used4;
        first_q  <= first4;
        last_q   <= last4;
        bsid_q   <= bsid2;
        bstime_q <= bstime2;
        if (is_begin) begin
          cur_sid_q    <= in_data_i.session_id;
          cur_stime_q  <= in_data_i.session_time;
          cur_fidx_q   <= WordW'(in_data_i.file_index);
          cur_stream_q <= in_data_i.stream_id;
          bytes_left_q <= in_data_i.data_length;
          open_q       <= open_after;
          need_q       <= post_end;
        end else if (is_pay) begin
          bytes_left_q <= left3;
          open_q       <= open_after;
          need_q       <= post_end;
        end else begin
          // Flush: an open record resumes behind a continuation header.
          need_q <= need_q || open_q;
        end
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for record_to_block_segmenter_core: directed rows,
// then random record traffic over several register settings, checked beat by beat
// against an in-bench model or a row's fixed beat. Depends on rtbs_pkg and the core.
module testbench;
  import rtbs_pkg::*;

  localparam int          IdleLimit     = 4000;  // cycles with no beat at all
  localparam int          DrainCycles   = 40;    // past the longest burst (22 beats)
  localparam int          HoldOffCycles = 300;
  localparam int          PhaseItems    = 24;
  localparam logic [1:0]  ReqUnused     = 2'd3;

  // Drive every input to a known value from time zero.
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [CfgDataW-1:0] pwdata    = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  record_to_block_segmenter_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Block model: registers, block fill, open record and per-block index span.
  // ---------------------------------------------------------------------------
  int unsigned cfg_cap   = 32'(CapReset);
  logic [6:0]  cfg_hb    = HbReset;
  logic [1:0]  cfg_ver   = HvReset;
  int unsigned fill      = 32'(HbReset);
  logic [31:0] remaining = '0;
  bit          rec_open  = 1'b0;
  bit          cont_due  = 1'b0;
  logic [31:0] rec_len   = '0;
  logic [30:0] rec_stream = '0;
  logic [31:0] rec_index = '0;
  logic [31:0] rec_sid   = '0;
  logic [31:0] rec_stime = '0;
  logic [30:0] idx_first = '0;
  logic [30:0] idx_last  = '0;
  logic [31:0] tag_sid   = '0;
  logic [31:0] tag_stime = '0;

  out_item_t   step_beats[$];   // beats the current request produces
  out_item_t   beats_due[$];    // beats still owed by the block, oldest first

  int  fails = 0;
  bit  calm = 1'b0;             // no idling on either side
  bit  hold_off_req = 1'b0;

  function automatic int unsigned hdr_size();
    return (cfg_ver == HdrVersionLong) ? 20 : 12;
  endfunction

  // Cap at the maximum block size, then raise so a fresh block takes a header
  // and at least one byte.
  function automatic int unsigned cap_eff();
    int unsigned c;
    int unsigned min_cap;
    c = (cfg_cap > 32'(MaxBlockBytes)) ? 32'(MaxBlockBytes) : cfg_cap;
    min_cap = 32'(cfg_hb) + hdr_size() + 2;
    return (c < min_cap) ? min_cap : c;
  endfunction

  function automatic int unsigned room_left();
    int unsigned c;
    c = cap_eff();
    return (fill < c) ? c - fill : 0;
  endfunction

  function automatic void push_beat(logic kind, logic [7:0] b, logic done,
                                    logic [22:0] used, logic [30:0] first,
                                    logic [30:0] last, logic [31:0] sid,
                                    logic [31:0] stime);
    out_item_t o;
    o = '0;
    o.kind               = kind;
    o.out_byte           = b;
    o.record_done        = done;
    o.block_used         = used;
    o.first_index        = first;
    o.last_index         = last;
    o.block_session_id   = sid;
    o.block_session_time = stime;
    step_beats.push_back(o);
  endfunction

  function automatic void close_block();
    push_beat(KindEnd, 8'd0, 1'b0, fill[22:0], idx_first, idx_last, tag_sid, tag_stime);
    fill      = 32'(cfg_hb);
    idx_first = '0;
    idx_last  = '0;
  endfunction

  function automatic void put_word(logic [31:0] w, logic done);
    push_beat(KindByte, w[31:24], 1'b0, '0, '0, '0, '0, '0);
    push_beat(KindByte, w[23:16], 1'b0, '0, '0, '0, '0, '0);
    push_beat(KindByte, w[15:8], 1'b0, '0, '0, '0, '0, '0);
    push_beat(KindByte, w[7:0], done, '0, '0, '0, '0, '0);
  endfunction

  function automatic void put_header(logic [31:0] stream_word, logic [31:0] len_word,
                                     logic done);
    if (cfg_ver == HdrVersionLong) begin
      put_word(rec_sid, 1'b0);
      put_word(rec_stime, 1'b0);
    end else begin
      // short headers carry no session; the block end reports it instead
      tag_sid   = rec_sid;
      tag_stime = rec_stime;
    end
    put_word(rec_index, 1'b0);
    put_word(stream_word, 1'b0);
    put_word(len_word, done);
    fill += hdr_size();
    if (rec_index != '0 && !rec_index[31]) begin
      if (idx_first == '0) idx_first = rec_index[30:0];
      idx_last = rec_index[30:0];
    end
  endfunction

  // Work out every beat one accepted request produces.
  function automatic void segment_item(in_item_t it);
    out_item_t tail;
    logic      done;
    int unsigned room;
    step_beats.delete();
    case (it.req_type)
      REQ_BEGIN: begin
        rec_sid    = it.session_id;
        rec_stime  = it.session_time;
        rec_index  = it.file_index;
        rec_stream = it.stream_id;
        rec_len    = it.data_length;
        cont_due   = 1'b0;
        if (room_left() < hdr_size()) close_block();
        done = (rec_len == '0);
        put_header({1'b0, rec_stream}, rec_len, done);
        remaining = rec_len;
        rec_open  = !done;
        // header filled the block with payload still to come
        if (rec_open && room_left() == 0) begin
          close_block();
          cont_due = 1'b1;
        end
      end
      REQ_PAYLOAD: begin
        if (rec_open) begin
          room = room_left();
          if ((cont_due && room < hdr_size() + 1) || (!cont_due && room == 0)) begin
            close_block();
            cont_due = 1'b1;
          end
          if (cont_due) begin
            put_header(32'd0 - {1'b0, rec_stream}, remaining, 1'b0);
            cont_due = 1'b0;
          end
          remaining = remaining - 32'd1;
          fill++;
          push_beat(KindByte, it.data_byte, remaining == '0, '0, '0, '0, '0, '0);
          if (remaining == '0) begin
            rec_open = 1'b0;
          end else if (room_left() == 0) begin
            close_block();
            cont_due = 1'b1;
          end
        end
      end
      REQ_FLUSH: begin
        close_block();
        if (rec_open) cont_due = 1'b1;
      end
      default: ;
    endcase
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last_of_run = 1'b1;
      step_beats.push_back(tail);
    end
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_CAPACITY: cfg_cap = 32'(v[22:0]);
      REG_HDR_BYTES: begin
        // an untouched block takes the new reservation at once
        if (fill == 32'(cfg_hb)) fill = 32'(v[6:0]);
        cfg_hb = v[6:0];
      end
      REG_VERSION: cfg_ver = v[1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders and directed rows.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit         is_reg;
    reg_idx_e   reg_sel;
    logic [31:0] reg_val;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } step_row_t;

  function automatic in_item_t open_req(logic [31:0] sid, logic [31:0] stime,
                                        logic [31:0] fi, logic [30:0] stream,
                                        logic [31:0] len);
    in_item_t it;
    it = '0;
    it.req_type     = REQ_BEGIN;
    it.session_id   = sid;
    it.session_time = stime;
    it.file_index   = fi;
    it.stream_id    = stream;
    it.data_length  = len;
    return it;
  endfunction

  function automatic in_item_t plain_req(logic [1:0] kind, logic [7:0] b);
    in_item_t it;
    it = '0;
    it.req_type  = kind;
    it.data_byte = b;
    return it;
  endfunction

  function automatic in_item_t rand_req(logic [1:0] kind);
    in_item_t it;
    it.req_type     = kind;
    it.session_id   = $urandom;
    it.session_time = $urandom;
    it.file_index   = $urandom;
    it.stream_id    = 31'($urandom);
    it.data_length  = $urandom;
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  function automatic out_item_t end_beat(logic [22:0] used, logic [30:0] first,
                                         logic [30:0] last, logic [31:0] sid,
                                         logic [31:0] stime);
    out_item_t o;
    o = '0;
    o.kind               = KindEnd;
    o.last_of_run        = 1'b1;
    o.block_used         = used;
    o.first_index        = first;
    o.last_index         = last;
    o.block_session_id   = sid;
    o.block_session_time = stime;
    return o;
  endfunction

  function automatic step_row_t item_row(in_item_t it);
    step_row_t r;
    r.is_reg  = 1'b0;
    r.reg_sel = REG_CAPACITY;
    r.reg_val = '0;
    r.item    = it;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic step_row_t typed_row(in_item_t it, out_item_t want);
    step_row_t r;
    r       = item_row(it);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic step_row_t reg_row(reg_idx_e idx, logic [31:0] v);
    step_row_t r;
    r         = item_row('0);
    r.is_reg  = 1'b1;
    r.reg_sel = idx;
    r.reg_val = v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the beat at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_req(input in_item_t it, input bit typed, input out_item_t want,
                          output int made);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat taken: predict now, before any of its output can show up
    segment_item(it);
    made = step_beats.size();
    if (typed) begin
      beats_due.push_back(want);
    end else begin
      foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
    end
  endtask

  // Drop valid and let the block run dry before touching a register.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] cap, input logic [31:0] hb,
                          input logic [31:0] ver);
    settle();
    reg_write(REG_CAPACITY, cap);
    reg_write(REG_HDR_BYTES, hb);
    reg_write(REG_VERSION, ver);
  endtask

  // Mostly well-formed records with random content; the rest is flushes,
  // records cut short by the next begin, stray bytes and unused requests.
  task automatic random_phase(input int target);
    int       got;
    int       pick;
    int       len;
    int       made;
    in_item_t it;
    got = 0;
    while (got < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        it = rand_req(REQ_BEGIN);
        if ($urandom_range(0, 7) == 0) begin
          it.file_index = '0;
        end else if ($urandom_range(0, 2) == 0) begin
          it.file_index = $urandom_range(1, 50);
        end
        if (pick < 70) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          it.data_length = len;
        end else begin
          len = $urandom_range(0, 5);  // declared length stays random: cut short
        end
        send_req(it, 1'b0, '0, made);
        got += int'(made > 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 29) == 0) begin
            send_req(rand_req(REQ_FLUSH), 1'b0, '0, made);
            got += int'(made > 0);
          end
          send_req(rand_req(REQ_PAYLOAD), 1'b0, '0, made);
          got += int'(made > 0);
        end
      end else if (pick < 88) begin
        send_req(rand_req(REQ_FLUSH), 1'b0, '0, made);
        got += int'(made > 0);
      end else begin
        send_req(rand_req($urandom_range(0, 1) ? ReqUnused : 2'(REQ_PAYLOAD)),
                 1'b0, '0, made);
        got += int'(made > 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, free stretches, one long hold-off.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int free_left  = 0;

  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left   = HoldOffCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (calm || free_left > 0) begin
      if (free_left > 0) free_left--;
      out_stall = 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall  = 1'b1;
    end else begin
      free_left = $urandom_range(1, 40);
      out_stall = 1'b0;
    end
  end

  // Compare every accepted out beat against the oldest expectation.
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("out beat with nothing expected: %h", out_data);
        fails++;
      end else begin
        want = beats_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("out_byte", 32'(want.out_byte), 32'(out_data.out_byte));
        check_field("record_done", 32'(want.record_done), 32'(out_data.record_done));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
        check_field("block_used", 32'(want.block_used), 32'(out_data.block_used));
        check_field("first_index", 32'(want.first_index), 32'(out_data.first_index));
        check_field("last_index", 32'(want.last_index), 32'(out_data.last_index));
        check_field("block_session_id", want.block_session_id,
                    out_data.block_session_id);
        check_field("block_session_time", want.block_session_time,
                    out_data.block_session_time);
      end
    end
  end

  // Watchdog: end the run when no beat moves on any port for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  step_row_t rows[$];

  initial begin
    int made;

    // Default registers: 64512-byte blocks, 24 reserved, short headers.
    rows.push_back(typed_row(plain_req(REQ_FLUSH, 8'h00),
                             end_beat(23'd24, '0, '0, '0, '0)));        // empty block
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'hFF)));            // no record: drop
    rows.push_back(item_row(plain_req(ReqUnused, 8'h00)));              // unused code: drop
    rows.push_back(item_row(open_req(32'hDEADBEEF, 32'h12345678, 32'd1, 31'd1, 32'd0)));
    rows.push_back(typed_row(plain_req(REQ_FLUSH, 8'h00),
                             end_beat(23'd36, 31'd1, 31'd1, 32'hDEADBEEF, 32'h12345678)));
    rows.push_back(item_row(open_req(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                     31'h7FFFFFFF, 32'd3)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h00)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'hFF)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'hA5)));
    rows.push_back(item_row(open_req(32'd0, 32'd0, 32'hFFFFFFFE, 31'd0, 32'd2)));  // label
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h5A)));
    // begin over an open record drops its rest
    rows.push_back(item_row(open_req(32'd1, 32'd2, 32'h80000000, 31'h40000000,
                                     32'hFFFFFFFF)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h3C)));
    rows.push_back(item_row(plain_req(REQ_FLUSH, 8'h00)));              // flush mid-record
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'hC3)));            // continuation header
    rows.push_back(item_row(plain_req(REQ_FLUSH, 8'h00)));
    // Tight blocks: 40 reserved + 12 + 12 fills 64 exactly.
    rows.push_back(reg_row(REG_CAPACITY, 32'd64));
    rows.push_back(reg_row(REG_HDR_BYTES, 32'd40));
    rows.push_back(item_row(open_req(32'h11, 32'h21, 32'd5, 31'd3, 32'd0)));
    rows.push_back(item_row(open_req(32'h12, 32'h22, 32'd6, 31'd3, 32'd0)));  // exact fill
    rows.push_back(item_row(open_req(32'h13, 32'h23, 32'd7, 31'd4, 32'd2)));  // no room
    // header lands on the block end with payload pending
    rows.push_back(item_row(open_req(32'h14, 32'h24, 32'd8, 31'd5, 32'd2)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h81)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h7E)));
    // payload lands on the block end: block stays open
    rows.push_back(reg_row(REG_CAPACITY, 32'd67));
    rows.push_back(item_row(open_req(32'h15, 32'h25, 32'd9, 31'd6, 32'd1)));
    rows.push_back(item_row(plain_req(REQ_PAYLOAD, 8'h42)));
    // shrink below the fill level, switch to long headers
    rows.push_back(reg_row(REG_CAPACITY, 32'd64));
    rows.push_back(reg_row(REG_VERSION, 32'(HdrVersionLong)));
    rows.push_back(item_row(open_req(32'h16, 32'h26, 32'hFFFFFFFB, 31'd7, 32'd0)));
    rows.push_back(item_row(plain_req(REQ_FLUSH, 8'h00)));

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        settle();
        reg_write(rows[i].reg_sel, rows[i].reg_val);
      end else begin
        send_req(rows[i].item, rows[i].typed, rows[i].want, made);
      end
    end

    // Random phases; capacities up to and beyond the maximum, every header version code.
    set_regs(32'd64, 32'd0, 32'd1);
    random_phase(PhaseItems);

    set_regs(32'd100, 32'd64, 32'd2);
    @(posedge clk);
    hold_off_req = 1'b1;                 // long receiver stall while we keep sending
    random_phase(PhaseItems);

    set_regs(32'd4194304, 32'd24, 32'd0);
    random_phase(PhaseItems);

    set_regs(32'h7FFFFF, 32'd10, 32'd3);  // beyond the maximum: capped
    random_phase(PhaseItems);

    // Last stretch: capacity below range gets raised; no idling anywhere.
    calm = 1'b1;
    set_regs($urandom_range(0, 63), $urandom_range(0, 64), 32'd1);
    random_phase(PhaseItems);

    @(negedge clk);
    in_valid = 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fails == 0 && beats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
